### sv/cpcm_pkg.sv
// ----------------------------------------------------------------------------
// cpcm_pkg: shared types for the closest-pair centroid merge block
// Size constants, controller states, command and status bundles, register
// indexes.
// ----------------------------------------------------------------------------
package cpcm_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int MAX_DIMS    = 16;
  localparam int COORD_WIDTH = 16;

  localparam logic [4:0] REG_POINT_COUNT = 5'd0;
  localparam logic [4:0] REG_DIM_COUNT   = 5'd1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PAIR,
    ST_ACC,
    ST_DRAIN,
    ST_OUTRD,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_wr;     // write incoming word, advance load position
    logic load_clr;    // restart loading
    logic pair_init;   // i=0,k=1, best reset
    logic acc_clr;     // clear accumulator, d=0
    logic acc_step;    // issue read for dimension d
    logic pair_done;   // compare and advance pair
    logic out_init;    // d=0 for output
    logic out_rd;      // read (and hold) the output dimension
    logic out_adv;     // advance output dimension
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic load_last;   // current word is the last of the run
    logic dim_last;    // current d is last dimension
    logic out_last;    // current output dimension is the last one
    logic pair_last;   // current pair is the last pair
    logic pipe_busy;   // squares still ahead of the accumulator
  } sts_t;

endpackage

### sv/cpcm_ram.sv
// ----------------------------------------------------------------------------
// cpcm_ram: generic single-write, dual-read RAM
// Registered read data on both ports.
// ----------------------------------------------------------------------------
module cpcm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### sv/cpcm_ctrl.sv
// ----------------------------------------------------------------------------
// cpcm_ctrl: sequencer for load, pair search and result drain
// Walks the pair loop one dimension per cycle, then one result per dimension.
// ----------------------------------------------------------------------------
module cpcm_ctrl
  import cpcm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_LOAD;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (cfg_we) begin
          cmd.load_clr = 1'b1;
          in_stall     = 1'b1;
        end else if (in_valid) begin
          cmd.load_wr = 1'b1;
          if (sts.load_last) begin
            cmd.pair_init = 1'b1;
            cmd.acc_clr   = 1'b1;
            state_nxt     = ST_ACC;
          end
        end
      end
      ST_PAIR: begin
        cmd.acc_clr = 1'b1;
        state_nxt   = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_step = 1'b1;
        if (sts.dim_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        // wait for the last square to reach the accumulator
        if (!sts.pipe_busy) begin
          state_nxt     = ST_PAIR;
          cmd.pair_done = 1'b1;
          if (sts.pair_last) begin
            cmd.out_init = 1'b1;
            state_nxt    = ST_OUTRD;
          end
        end
      end
      ST_OUTRD: begin
        cmd.out_rd = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        // keep the read address so a stalled word holds
        cmd.out_rd = 1'b1;
        out_valid  = 1'b1;
        if (!out_stall) begin
          cmd.out_adv = 1'b1;
          state_nxt   = sts.out_last ? ST_LOAD : ST_OUTRD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

endmodule

### sv/cpcm_dp.sv
// ----------------------------------------------------------------------------
// cpcm_dp: datapath with point store, distance accumulator and best pair
// Accumulates one squared difference per cycle through a short pipeline.
// ----------------------------------------------------------------------------
module cpcm_dp
  import cpcm_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [4:0]                   cfg_index,
  input  logic [6:0]                   cfg_data,
  input  logic signed [COORD_WIDTH-1:0] in_coordinate,
  input  cmd_t                         cmd,
  output sts_t                         sts,
  output logic [5:0]                   first_index,
  output logic [5:0]                   second_index,
  output logic [35:0]                  squared_distance,
  output logic signed [COORD_WIDTH-1:0] merged_coordinate,
  output logic                         last_of_run
);

  localparam int PW = $clog2(MAX_POINTS);
  localparam int AW = $clog2(MAX_POINTS * MAX_DIMS);
  localparam int SQW = 2 * COORD_WIDTH;

  // registers and effective counts
  logic [6:0] pcount_r;
  logic [4:0] dcount_r;
  logic [6:0] eff_p;
  logic [6:0] eff_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r <= 7'd64;
      dcount_r <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POINT_COUNT: pcount_r <= cfg_data;
        REG_DIM_COUNT:   dcount_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_p = pcount_r;
    if (pcount_r < 7'd2) eff_p = 7'd2;
    if (32'(pcount_r) > MAX_POINTS) eff_p = 7'(MAX_POINTS);
    eff_d = {2'b0, dcount_r};
    if (dcount_r == 5'd0) eff_d = 7'd1;
    if (32'(dcount_r) > MAX_DIMS) eff_d = 7'(MAX_DIMS);
  end

  // only a write to a known register drops a partial load
  logic load_rst;
  assign load_rst = cmd.load_clr &&
                    (cfg_index == REG_POINT_COUNT || cfg_index == REG_DIM_COUNT);

  // load position kept as point and dimension counters
  logic [PW:0] lp_r;
  logic [6:0]  ld_r;

  always_ff @(posedge clk) begin
    if (!rst_n || load_rst) begin
      lp_r <= '0;
      ld_r <= '0;
    end else if (cmd.load_wr) begin
      if (ld_r + 7'd1 == eff_d) begin
        ld_r <= '0;
        lp_r <= (sts.load_last) ? '0 : lp_r + 1'b1;
      end else begin
        ld_r <= ld_r + 7'd1;
      end
    end
  end

  // search counters
  logic [PW-1:0] i_r, k_r;
  logic [6:0]    d_r;
  logic [6:0]    od_r;
  logic [PW-1:0] ra_p, rb_p;
  logic [6:0]    rd;

  // read valid pipe: read -> diff -> square -> accumulate
  logic v1_r, v2_r, v3_r;

  always_comb begin
    sts.load_last = (ld_r + 7'd1 == eff_d) && (7'(lp_r) + 7'd1 == eff_p);
    sts.dim_last  = (d_r + 7'd1 == eff_d);
    sts.out_last  = (od_r + 7'd1 == eff_d);
    sts.pair_last = (7'(i_r) + 7'd2 == eff_p) && (7'(k_r) + 7'd1 == eff_p);
    sts.pipe_busy = v1_r || v2_r;
  end

  // store
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [COORD_WIDTH-1:0] rdata_a, rdata_b;

  assign waddr = AW'(lp_r[PW-1:0]) * AW'(MAX_DIMS) + AW'(ld_r);
  assign ra_p  = cmd.out_rd ? first_index  : i_r;
  assign rb_p  = cmd.out_rd ? second_index : k_r;
  assign rd    = cmd.out_rd ? od_r : d_r;
  assign raddr_a = AW'(ra_p) * AW'(MAX_DIMS) + AW'(rd);
  assign raddr_b = AW'(rb_p) * AW'(MAX_DIMS) + AW'(rd);

  cpcm_ram #(.WIDTH(COORD_WIDTH), .DEPTH(MAX_POINTS * MAX_DIMS)) u_store (
    .clk     (clk),
    .we      (cmd.load_wr),
    .waddr   (waddr),
    .wdata   (in_coordinate),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  logic signed [COORD_WIDTH:0] diff_r;
  logic [COORD_WIDTH-1:0] adiff;
  logic [SQW-1:0] sq_w;
  logic [SQW-1:0] sq_r;
  logic [36:0]    acc_r;
  logic [36:0]    best_r;

  // magnitude of the difference always fits the coordinate width
  assign adiff = diff_r[COORD_WIDTH] ? COORD_WIDTH'(-diff_r) : diff_r[COORD_WIDTH-1:0];
  assign sq_w  = adiff * adiff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.acc_step;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    diff_r <= $signed({rdata_a[COORD_WIDTH-1], rdata_a})
            - $signed({rdata_b[COORD_WIDTH-1], rdata_b});
    sq_r   <= sq_w;
  end

  // final accumulated sum: acc plus the square still in flight
  logic [36:0] pair_dist;
  assign pair_dist = acc_r + (v3_r ? 37'(sq_r) : 37'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0; k_r <= '0; d_r <= '0; od_r <= '0;
      acc_r <= '0;
      best_r <= '1;
      first_index <= '0;
      second_index <= '0;
    end else begin
      if (cmd.acc_clr) begin
        acc_r <= '0;
        d_r   <= '0;
      end else begin
        if (v3_r) acc_r <= acc_r + 37'(sq_r);
        if (cmd.acc_step) d_r <= d_r + 7'd1;
      end
      if (cmd.pair_init) begin
        i_r <= '0;
        k_r <= PW'(1);
        best_r <= '1;
        first_index <= '0;
        second_index <= '0;
      end
      if (cmd.pair_done) begin
        if (pair_dist < best_r) begin
          best_r       <= pair_dist;
          first_index  <= 6'(i_r);
          second_index <= 6'(k_r);
        end
        if (7'(k_r) + 7'd1 == eff_p) begin
          i_r <= i_r + 1'b1;
          k_r <= i_r + PW'(2);
        end else begin
          k_r <= k_r + 1'b1;
        end
      end
      if (cmd.out_init) od_r <= '0;
      if (cmd.out_adv)  od_r <= od_r + 7'd1;
    end
  end

  // merged centroid: floor of sum halved is an arithmetic shift
  logic signed [COORD_WIDTH:0] msum;
  assign msum = $signed({rdata_a[COORD_WIDTH-1], rdata_a})
              + $signed({rdata_b[COORD_WIDTH-1], rdata_b});
  assign merged_coordinate = msum[COORD_WIDTH:1];
  assign squared_distance  = best_r[35:0];
  assign last_of_run       = (od_r + 7'd1 == eff_d);

endmodule

### sv/closest_pair_centroid_merge.sv
// ----------------------------------------------------------------------------
// closest_pair_centroid_merge: centroid-linkage closest pair and merge
// Loads one coordinate per cycle while in_stall is low, then searches all
// N = P*(P-1)/2 pairs i<k. Each pair takes D store reads, a drain of the
// square pipe and a restart of the accumulator.
// Results: one word per dimension, each read from the store and then held
// until taken; input stalls meanwhile.
// Reset: synchronous active low; registers return to 64 points, 16 dims.
// ----------------------------------------------------------------------------
module closest_pair_centroid_merge
  import cpcm_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [4:0]                    cfg_index,
  input  logic [6:0]                    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_coordinate,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [5:0]                    out_first_index,
  output logic [5:0]                    out_second_index,
  output logic [35:0]                   out_squared_distance,
  output logic signed [COORD_WIDTH-1:0] out_merged_coordinate,
  output logic                          out_last_of_run
);

  cmd_t cmd;
  sts_t sts;

  cpcm_ctrl u_ctrl (
    .clk, .rst_n, .cfg_we, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts, .cmd
  );

  cpcm_dp u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .in_coordinate,
    .cmd, .sts,
    .first_index       (out_first_index),
    .second_index      (out_second_index),
    .squared_distance  (out_squared_distance),
    .merged_coordinate (out_merged_coordinate),
    .last_of_run       (out_last_of_run)
  );

endmodule

### dv/closest_pair_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_pair_checker: scoreboard for the closest-pair centroid merge block
// Watches the register port and both channels, keeps its own copy of the
// point store, runs the pair search on each completed load and compares
// every result word field by field with the oldest predicted word.
// ----------------------------------------------------------------------------
module closest_pair_checker
  import cpcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_coordinate,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [5:0]         out_first_index,
  input  logic [5:0]         out_second_index,
  input  logic [35:0]        out_squared_distance,
  input  logic signed [15:0] out_merged_coordinate,
  input  logic               out_last_of_run,
  output int                 errors,
  output int                 pending,
  output int                 merges_seen
);

  typedef struct packed {
    logic [5:0]         first_idx;
    logic [5:0]         second_idx;
    logic [35:0]        sq_dist;
    logic signed [15:0] merged;
    logic               last;
  } merge_word_t;

  merge_word_t        merge_q[$];
  logic signed [15:0] point_mem [0:63][0:15];
  int unsigned        load_pos;
  logic [6:0]         point_reg;
  logic [4:0]         dim_reg;

  function automatic int unsigned live_points();
    if (point_reg < 2) return 2;
    if (point_reg > 64) return 64;
    return point_reg;
  endfunction

  function automatic int unsigned live_dims();
    if (dim_reg < 1) return 1;
    if (dim_reg > 16) return 16;
    return dim_reg;
  endfunction

  // full pair scan, first strict minimum wins, then one word per dimension
  task automatic plan_merge();
    int unsigned        npts;
    int unsigned        ndim;
    longint unsigned    best;
    longint unsigned    dsum;
    longint             diff;
    int                 bi;
    int                 bk;
    logic signed [16:0] s;
    merge_word_t        w;
    npts = live_points();
    ndim = live_dims();
    best = 64'h1F_FFFF_FFFF;
    bi = 0;
    bk = 0;
    for (int i = 0; i < npts; i++) begin
      for (int k = i + 1; k < npts; k++) begin
        dsum = 0;
        for (int d = 0; d < ndim; d++) begin
          diff = longint'(point_mem[i][d]) - longint'(point_mem[k][d]);
          if (diff < 0) diff = -diff;
          dsum += diff * diff;
        end
        if (dsum < best) begin
          best = dsum;
          bi = i;
          bk = k;
        end
      end
    end
    for (int d = 0; d < ndim; d++) begin
      s = 17'(point_mem[bi][d]) + 17'(point_mem[bk][d]);
      w.first_idx  = 6'(bi);
      w.second_idx = 6'(bk);
      w.sq_dist    = best[35:0];
      w.merged     = s[16:1];
      w.last       = (d == ndim - 1);
      merge_q = {merge_q, w};
    end
  endtask

  task automatic flag(input string field, input longint exp_v, input longint act_v);
    errors++;
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, exp_v, act_v);
  endtask

  initial begin
    errors = 0;
    pending = 0;
    merges_seen = 0;
  end

  always @(posedge clk) begin
    merge_word_t w;
    int unsigned ndim;
    if (!rst_n) begin
      load_pos  = 0;
      point_reg = 7'd64;
      dim_reg   = 5'd16;
      merge_q.delete();
    end else begin
      // writes to a known register drop any partial load
      if (cfg_we) begin
        if (cfg_index == REG_POINT_COUNT) begin
          point_reg = cfg_data;
          load_pos = 0;
        end else if (cfg_index == REG_DIM_COUNT) begin
          dim_reg = cfg_data[4:0];
          load_pos = 0;
        end
      end
      // coordinate word accepted
      if (in_valid && !in_stall) begin
        ndim = live_dims();
        point_mem[load_pos / ndim][load_pos % ndim] = in_coordinate;
        load_pos++;
        if (load_pos >= live_points() * ndim) begin
          load_pos = 0;
          plan_merge();
        end
      end
      // result word accepted
      if (out_valid && !out_stall) begin
        if (merge_q.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing expected", $time);
        end else begin
          w = merge_q.pop_front();
          if (out_first_index !== w.first_idx)
            flag("first_index", w.first_idx, out_first_index);
          if (out_second_index !== w.second_idx)
            flag("second_index", w.second_idx, out_second_index);
          if (out_squared_distance !== w.sq_dist)
            flag("squared_distance", w.sq_dist, out_squared_distance);
          if (out_merged_coordinate !== w.merged)
            flag("merged_coordinate", w.merged, out_merged_coordinate);
          if (out_last_of_run !== w.last)
            flag("last_of_run", w.last, out_last_of_run);
          if (w.last) merges_seen++;
        end
      end
    end
    pending <= merge_q.size();
  end

endmodule

### dv/tb_closest_pair_centroid_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_closest_pair_centroid_merge: stimulus and verdict for the merge block
// Directed loads hit clamped sizes, extreme coordinates, ties and a dropped
// partial load; random loads of mostly small sizes follow, with random
// gaps on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_closest_pair_centroid_merge;
  import cpcm_pkg::*;

  localparam logic [4:0] REG_NONE = 5'd31;   // decodes to no register
  localparam int LIMIT = 1_500_000;
  localparam int HOLD_CYCLES = 400;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [4:0]         cfg_index;
  logic [6:0]         cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_coordinate;
  logic               out_valid;
  logic               out_stall;
  logic [5:0]         out_first_index;
  logic [5:0]         out_second_index;
  logic [35:0]        out_squared_distance;
  logic signed [15:0] out_merged_coordinate;
  logic               out_last_of_run;

  int          errors;
  int          pending;
  int          merges_seen;
  int          words_sent;
  int          cycles;
  logic        calm;
  logic        hold_go;
  int unsigned run_pts;
  int unsigned run_dims;

  closest_pair_centroid_merge dut (.*);

  closest_pair_checker u_chk (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_go = 1'b0;
      end
      out_stall <= !calm && ($urandom_range(99) < 37);
    end
  end

  task automatic push_word(input logic signed [15:0] c);
    while (!calm && ($urandom_range(99) < 37)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_coordinate <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic idle_until_drained();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [4:0] idx, input logic [6:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_size(input logic [6:0] pts, input logic [6:0] dims);
    idle_until_drained();
    write_reg(REG_POINT_COUNT, pts);
    write_reg(REG_DIM_COUNT, dims);
    run_pts  = (pts < 2) ? 2 : (pts > 64) ? 64 : pts;
    run_dims = (dims[4:0] < 1) ? 1 : (dims[4:0] > 16) ? 16 : dims[4:0];
  endtask

  // one full load; flavor picks wide, clustered (ties) or extreme values
  task automatic load_random(input int flavor);
    logic signed [15:0] c;
    for (int n = 0; n < run_pts * run_dims; n++) begin
      case (flavor)
        0: c = 16'($urandom);
        1: c = 16'($urandom_range(6)) - 16'sd3;
        default: begin
          case ($urandom_range(3))
            0: c = 16'sd32767;
            1: c = -16'sd32768;
            2: c = 16'sd0;
            default: c = -16'sd1;
          endcase
        end
      endcase
      push_word(c);
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_POINT_COUNT;
    cfg_data      <= 7'd0;
    in_valid      <= 1'b0;
    in_coordinate <= 16'sd0;
    calm          = 1'b0;
    hold_go       = 1'b0;
    cycles        = 0;
    words_sent    = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // clamped low sizes: 2 points of 1 dim, extreme spread then equal
    set_size(7'd0, 7'd0);
    push_word(16'sd32767);
    push_word(-16'sd32768);
    push_word(-16'sd32768);
    push_word(-16'sd32768);

    // ties: first pair in scan order wins
    set_size(7'd3, 7'd2);
    push_word(16'sd0);
    push_word(16'sd0);
    push_word(16'sd1);
    push_word(16'sd0);
    push_word(16'sd2);
    push_word(16'sd0);

    // partial load dropped by a register write, unknown index ignored
    push_word(16'sd100);
    push_word(-16'sd100);
    idle_until_drained();
    write_reg(REG_NONE, 7'd5);
    write_reg(REG_POINT_COUNT, 7'd3);
    push_word(-16'sd5);
    push_word(16'sd7);
    push_word(16'sd9);
    push_word(-16'sd3);
    push_word(-16'sd5);
    push_word(16'sd8);

    // clamped high dims: largest possible distance
    set_size(7'd2, 7'h7F);
    for (int n = 0; n < 32; n++)
      push_word(n < 16 ? 16'sd32767 : -16'sd32768);

    // clamped high points, one dim
    set_size(7'h7F, 7'd1);
    load_random(0);

    // long receiver hold-off while loads keep coming
    set_size(7'd3, 7'd4);
    calm = 1'b1;
    hold_go = 1'b1;
    for (int r = 0; r < 4; r++) load_random(r % 3);
    calm = 1'b0;

    // random sizes, mostly small
    while (words_sent < 380) begin
      if ($urandom_range(9) == 0)
        set_size(7'($urandom_range(127)), 7'($urandom_range(127)));
      else
        set_size(7'($urandom_range(2, 6)), 7'($urandom_range(1, 4)));
      if (run_pts * run_dims > 128) begin
        run_pts = $urandom_range(2, 8);
        write_reg(REG_POINT_COUNT, 7'(run_pts));
      end
      calm = ($urandom_range(7) == 0);
      for (int r = $urandom_range(1, 3); r > 0; r--) begin
        load_random($urandom_range(2));
        if ($urandom_range(3) == 0) idle_until_drained();
      end
      calm = 1'b0;
    end

    idle_until_drained();
    repeat (40) @(posedge clk);
    $display("Run covered %0d merges over clamped, tied, extreme and random loads.",
             merges_seen);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
